// ----- src/power_switch_controller_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Power switch controller assertion macros
// Concurrent assertion helpers shared by the controller RTL files.
// ----------------------------------------------------------------------------
`ifndef POWER_SWITCH_CONTROLLER_UNIT_MACROS_SVH
`define POWER_SWITCH_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define PSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define PSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define PSC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PSC_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- src/psc_pkg.sv -----
// ----------------------------------------------------------------------------
// Power switch controller package
// Shared types, register map and constants of the power switch controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    // Counter widths.
    localparam int WAIT_BITS  = 14;
    localparam int PRESS_BITS = 16;

    // Register field widths.
    localparam int CFG_PRESS_W = 16;
    localparam int CFG_WAIT_W  = 14;

    localparam int WAIT_CMP_W  = (WAIT_BITS > CFG_WAIT_W) ? WAIT_BITS : CFG_WAIT_W;
    localparam int PRESS_CMP_W = (PRESS_BITS > CFG_PRESS_W) ? PRESS_BITS : CFG_PRESS_W;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register reset values.
    localparam logic [CFG_PRESS_W-1:0] RST_PRESS_OFF     = CFG_PRESS_W'(2000);
    localparam logic [CFG_WAIT_W-1:0]  RST_TURN_ON_DELAY = CFG_WAIT_W'(5000);
    localparam logic [CFG_WAIT_W-1:0]  RST_SHUTDOWN_WAIT = CFG_WAIT_W'(10000);
    localparam logic                   RST_CLEAR_PRECHG  = 1'b1;

    typedef enum logic [1:0] {
        REG_PRESS_OFF      = 2'd0,
        REG_TURN_ON_DELAY  = 2'd1,
        REG_SHUTDOWN_WAIT  = 2'd2,
        REG_CLEAR_PRECHG   = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_BOOTED  = 3'd0,
        PH_DELAY   = 3'd1,
        PH_RELEASE = 3'd2,
        PH_ON      = 3'd3,
        PH_DOWN    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        BRIGHT_OFF     = 2'd0,
        BRIGHT_HALF    = 2'd1,
        BRIGHT_FULL    = 2'd2,
        BRIGHT_INITIAL = 2'd3
    } bright_t;

    typedef struct packed {
        logic [CFG_PRESS_W-1:0] press_off_ticks;
        logic [CFG_WAIT_W-1:0]  turn_on_delay_ticks;
        logic [CFG_WAIT_W-1:0]  shutdown_wait_ticks;
        logic                   clear_precharge_on_off;
    } cfg_t;

    typedef struct packed {
        logic    power_hold;
        logic    precharge_on;
        bright_t brightness_level;
        logic    bus_shutdown_pulse;
        phase_t  phase_code;
    } result_t;

endpackage

`default_nettype wire

// ----- src/psc_seq.sv -----
// ----------------------------------------------------------------------------
// Power switch sequencer
// Holds the power sequence state and advances it by one tick per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "power_switch_controller_unit_macros.svh"

module psc_seq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            tick_en,
    input  wire logic            button_pressed,
    input  wire psc_pkg::cfg_t   cfg,
    output psc_pkg::result_t     res
);
    import psc_pkg::*;

    localparam logic [WAIT_BITS-1:0]  WAIT_MAX  = '1;
    localparam logic [PRESS_BITS-1:0] PRESS_MAX = '1;

    phase_t                phase_reg, phase_next;
    logic [WAIT_BITS-1:0]  wait_count_reg, wait_count_next;
    logic [PRESS_BITS-1:0] press_count_reg, press_count_next;
    logic                  hold_reg, hold_next;
    logic                  precharge_reg, precharge_next;
    bright_t               bright_reg, bright_next;
    logic                  pulse;

    logic [WAIT_BITS-1:0]  wait_inc;
    logic                  delay_done;
    logic                  down_done;
    logic [PRESS_BITS-1:0] press_upd;

    always_comb begin
        wait_inc = (wait_count_reg == WAIT_MAX) ? wait_count_reg
                                                : wait_count_reg + WAIT_BITS'(1);
        delay_done = (WAIT_CMP_W'(wait_inc) >= WAIT_CMP_W'(cfg.turn_on_delay_ticks))
                     || (wait_inc == WAIT_MAX);
        down_done  = (WAIT_CMP_W'(wait_count_reg) >= WAIT_CMP_W'(cfg.shutdown_wait_ticks))
                     || (wait_count_reg == WAIT_MAX);
        if (button_pressed) begin
            press_upd = (press_count_reg == PRESS_MAX) ? press_count_reg
                                                       : press_count_reg + PRESS_BITS'(1);
        end else begin
            press_upd = '0;
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        wait_count_next  = wait_count_reg;
        press_count_next = press_count_reg;
        hold_next        = hold_reg;
        precharge_next   = precharge_reg;
        bright_next      = bright_reg;
        pulse            = 1'b0;

        unique case (phase_reg)
            PH_BOOTED: begin
                phase_next = PH_DELAY;
            end
            PH_DELAY: begin
                if (delay_done) begin
                    precharge_next  = 1'b1;
                    wait_count_next = '0;
                    phase_next      = PH_RELEASE;
                end else begin
                    wait_count_next = wait_inc;
                end
            end
            PH_RELEASE: begin
                hold_next = 1'b1;
                if (!button_pressed) begin
                    phase_next = PH_ON;
                end
            end
            PH_ON: begin
                press_count_next = press_upd;
                bright_next      = button_pressed ? BRIGHT_FULL : BRIGHT_HALF;
                if (PRESS_CMP_W'(press_upd) > PRESS_CMP_W'(cfg.press_off_ticks)) begin
                    wait_count_next = '0;
                    phase_next      = PH_DOWN;
                end
            end
            PH_DOWN: begin
                // The first tick of a shutdown is marked by a zero wait count.
                if (wait_count_reg == '0) begin
                    bright_next     = BRIGHT_OFF;
                    hold_next       = 1'b0;
                    if (cfg.clear_precharge_on_off) begin
                        precharge_next = 1'b0;
                    end
                    pulse           = 1'b1;
                    wait_count_next = WAIT_BITS'(1);
                end else if (down_done) begin
                    hold_next       = 1'b1;
                    wait_count_next = '0;
                    phase_next      = PH_DELAY;
                end else begin
                    wait_count_next = wait_count_reg + WAIT_BITS'(1);
                end
            end
            default: begin
                phase_next = PH_BOOTED;
            end
        endcase

        res.power_hold         = hold_next;
        res.precharge_on       = precharge_next;
        res.brightness_level   = bright_next;
        res.bus_shutdown_pulse = pulse;
        res.phase_code         = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_BOOTED;
            wait_count_reg  <= '0;
            press_count_reg <= '0;
            hold_reg        <= 1'b1;
            precharge_reg   <= 1'b0;
            bright_reg      <= BRIGHT_INITIAL;
        end else if (tick_en) begin
            phase_reg       <= phase_next;
            wait_count_reg  <= wait_count_next;
            press_count_reg <= press_count_next;
            hold_reg        <= hold_next;
            precharge_reg   <= precharge_next;
            bright_reg      <= bright_next;
        end
    end

    `PSC_ASSERT_IMP(a_pulse_only_in_down, aclk, aresetn, pulse, (phase_reg == PH_DOWN) && (wait_count_reg == '0))
    `PSC_ASSERT_IMP(a_hold_low_while_waiting, aclk, aresetn, (phase_reg == PH_DOWN) && (wait_count_reg != '0), !hold_reg)
    `PSC_ASSERT_NXT(a_release_sets_hold, aclk, aresetn, tick_en && (phase_reg == PH_RELEASE), hold_reg)

endmodule

`default_nettype wire

// ----- src/power_switch_controller_unit.sv -----
// A taken word's result is registered in the output or, on a stall, the skid register.
// One word per cycle while s_ready is high; a two-entry output stage keeps it high under one stall.
// s_ready drops only while both the output register and the skid register hold words.
// Reset: synchronous, active low; the sequence restarts in the booted phase with power held on
// and all configuration registers back at their defaults.
// ----------------------------------------------------------------------------
// Power switch controller
// Tick-driven power sequencer with an APB register port and a buffered result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "power_switch_controller_unit_macros.svh"

module power_switch_controller_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // APB register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [psc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [psc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [psc_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready,
    // Input word
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_button_pressed,
    // Result word
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_power_hold,
    output logic                               m_precharge_on,
    output logic      [1:0]                    m_brightness_level,
    output logic                               m_bus_shutdown_pulse,
    output logic      [2:0]                    m_phase_code
);
    import psc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_wr;

    logic     in_accept;
    result_t  res;
    result_t  out_reg;
    result_t  skid_reg;
    logic     out_valid_reg;
    logic     skid_valid_reg;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_off_ticks        <= RST_PRESS_OFF;
            cfg_reg.turn_on_delay_ticks    <= RST_TURN_ON_DELAY;
            cfg_reg.shutdown_wait_ticks    <= RST_SHUTDOWN_WAIT;
            cfg_reg.clear_precharge_on_off <= RST_CLEAR_PRECHG;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PRESS_OFF:     cfg_reg.press_off_ticks     <= pwdata[CFG_PRESS_W-1:0];
                REG_TURN_ON_DELAY: cfg_reg.turn_on_delay_ticks <= pwdata[CFG_WAIT_W-1:0];
                REG_SHUTDOWN_WAIT: cfg_reg.shutdown_wait_ticks <= pwdata[CFG_WAIT_W-1:0];
                REG_CLEAR_PRECHG:  cfg_reg.clear_precharge_on_off <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PRESS_OFF:     prdata = APB_DATA_W'(cfg_reg.press_off_ticks);
            REG_TURN_ON_DELAY: prdata = APB_DATA_W'(cfg_reg.turn_on_delay_ticks);
            REG_SHUTDOWN_WAIT: prdata = APB_DATA_W'(cfg_reg.shutdown_wait_ticks);
            REG_CLEAR_PRECHG:  prdata = APB_DATA_W'(cfg_reg.clear_precharge_on_off);
            default:           prdata = '0;
        endcase
    end

    assign s_ready   = !skid_valid_reg;
    assign in_accept = s_valid && s_ready;

    psc_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tick_en        (in_accept),
        .button_pressed (s_button_pressed),
        .cfg            (cfg_reg),
        .res            (res)
    );

    // The skid register catches a word that arrives while the output word is stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_accept;
            end
        end else if (in_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (in_accept) begin
                out_reg <= res;
            end
        end else if (in_accept) begin
            skid_reg <= res;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_power_hold         = out_reg.power_hold;
    assign m_precharge_on       = out_reg.precharge_on;
    assign m_brightness_level   = out_reg.brightness_level;
    assign m_bus_shutdown_pulse = out_reg.bus_shutdown_pulse;
    assign m_phase_code         = out_reg.phase_code;

    `PSC_ASSERT_IMP(a_skid_needs_output, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `PSC_ASSERT_NXT(a_stall_fills_skid, aclk, aresetn, out_valid_reg && !m_ready && in_accept, skid_valid_reg && out_valid_reg)

endmodule

`default_nettype wire

// ----- tb/tb_power_switch_controller_unit.sv -----
// ----------------------------------------------------------------------------
// Power switch controller testbench
// Drives button words into the controller and checks every result word against
// a cycle-free model of the power sequence kept inside the bench. Register
// settings change only while the block is drained; each write is read back.
// A short directed part walks the sequence by hand, then randomized button
// runs sweep small settings, and a last run holds the button under the
// highest threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_power_switch_controller_unit;
    import psc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PERCENT   = 18;
    localparam logic [WAIT_BITS-1:0]  WAIT_TOP  = '1;
    localparam logic [PRESS_BITS-1:0] PRESS_TOP = '1;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic                  s_button_pressed = 1'b0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic                  m_power_hold;
    logic                  m_precharge_on;
    logic [1:0]            m_brightness_level;
    logic                  m_bus_shutdown_pulse;
    logic [2:0]            m_phase_code;

    power_switch_controller_unit dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_button_pressed     (s_button_pressed),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_power_hold         (m_power_hold),
        .m_precharge_on       (m_precharge_on),
        .m_brightness_level   (m_brightness_level),
        .m_bus_shutdown_pulse (m_bus_shutdown_pulse),
        .m_phase_code         (m_phase_code)
    );

    // Shadow copies of the registers.
    logic [CFG_PRESS_W-1:0] press_off_reg;
    logic [CFG_WAIT_W-1:0]  turn_on_reg;
    logic [CFG_WAIT_W-1:0]  shutdown_reg;
    logic                   clear_prechg_reg;

    // Sequence state as the block should hold it.
    phase_t                 seq_phase;
    logic [WAIT_BITS-1:0]   seq_wait;
    logic [PRESS_BITS-1:0]  seq_press;
    logic                   seq_hold;
    logic                   seq_precharge;
    bright_t                seq_bright;

    logic        button_q[$];
    result_t     expected_q[$];
    result_t     head_result;
    logic        steady = 1'b0;
    int unsigned words_queued  = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles  = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Advances the sequence by one tick and records the word it should report.
    task automatic step_sequence(input logic pressed);
        logic    pulse;
        result_t r;
        pulse = 1'b0;
        case (seq_phase)
            PH_BOOTED: begin
                seq_phase = PH_DELAY;
            end
            PH_DELAY: begin
                if (seq_wait != WAIT_TOP) seq_wait = seq_wait + 1'b1;
                if (seq_wait >= turn_on_reg || seq_wait == WAIT_TOP) begin
                    seq_precharge = 1'b1;
                    seq_wait      = '0;
                    seq_phase     = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                seq_hold = 1'b1;
                if (!pressed) seq_phase = PH_ON;
            end
            PH_ON: begin
                if (pressed) begin
                    if (seq_press != PRESS_TOP) seq_press = seq_press + 1'b1;
                    seq_bright = BRIGHT_FULL;
                end else begin
                    seq_press  = '0;
                    seq_bright = BRIGHT_HALF;
                end
                if (seq_press > press_off_reg) begin
                    seq_wait  = '0;
                    seq_phase = PH_DOWN;
                end
            end
            PH_DOWN: begin
                if (seq_wait == '0) begin
                    seq_bright = BRIGHT_OFF;
                    seq_hold   = 1'b0;
                    if (clear_prechg_reg) seq_precharge = 1'b0;
                    pulse    = 1'b1;
                    seq_wait = WAIT_BITS'(1);
                end else if (seq_wait >= shutdown_reg || seq_wait == WAIT_TOP) begin
                    seq_hold  = 1'b1;
                    seq_wait  = '0;
                    seq_phase = PH_DELAY;
                end else begin
                    seq_wait = seq_wait + 1'b1;
                end
            end
            default: begin
                seq_phase = PH_BOOTED;
            end
        endcase
        r.power_hold         = seq_hold;
        r.precharge_on       = seq_precharge;
        r.brightness_level   = seq_bright;
        r.bus_shutdown_pulse = pulse;
        r.phase_code         = seq_phase;
        expected_q.push_back(r);
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic logic [APB_DATA_W-1:0] reg_value(reg_idx_t idx);
        case (idx)
            REG_PRESS_OFF:     reg_value = APB_DATA_W'(press_off_reg);
            REG_TURN_ON_DELAY: reg_value = APB_DATA_W'(turn_on_reg);
            REG_SHUTDOWN_WAIT: reg_value = APB_DATA_W'(shutdown_reg);
            default:           reg_value = APB_DATA_W'(clear_prechg_reg);
        endcase
    endfunction

    // Input driver: a new word is offered only once the previous one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) step_sequence(s_button_pressed);
            if (!s_valid || s_ready) begin
                if (button_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    s_valid          <= 1'b1;
                    s_button_pressed <= button_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result word with nothing expected, phase_code %0d",
                             $time, m_phase_code);
                end else begin
                    head_result = expected_q.pop_front();
                    check_field("power_hold", head_result.power_hold, m_power_hold);
                    check_field("precharge_on", head_result.precharge_on, m_precharge_on);
                    check_field("brightness_level", head_result.brightness_level,
                                m_brightness_level);
                    check_field("bus_shutdown_pulse", head_result.bus_shutdown_pulse,
                                m_bus_shutdown_pulse);
                    check_field("phase_code", head_result.phase_code, m_phase_code);
                end
            end
            m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("tb_power_switch_controller_unit failed");
                $finish;
            end
        end
    end

    task automatic apb_access(input logic wr, input reg_idx_t idx,
                              input logic [APB_DATA_W-1:0] data,
                              output logic [APB_DATA_W-1:0] rd);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input reg_idx_t idx);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== reg_value(idx)) begin
            mismatch_count++;
            $display("%0t: register %s read expected %0d, actual %0d",
                     $time, idx.name(), reg_value(idx), rd);
        end
    endtask

    task automatic program_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, idx, value, rd);
        case (idx)
            REG_PRESS_OFF:     press_off_reg    = value[CFG_PRESS_W-1:0];
            REG_TURN_ON_DELAY: turn_on_reg      = value[CFG_WAIT_W-1:0];
            REG_SHUTDOWN_WAIT: shutdown_reg     = value[CFG_WAIT_W-1:0];
            default:           clear_prechg_reg = value[0];
        endcase
    endtask

    task automatic check_all_regs();
        check_reg(REG_PRESS_OFF);
        check_reg(REG_TURN_ON_DELAY);
        check_reg(REG_SHUTDOWN_WAIT);
        check_reg(REG_CLEAR_PRECHG);
    endtask

    task automatic program_all(input int press_off, input int turn_on, input int shutdown,
                               input int clear_prechg);
        program_reg(REG_PRESS_OFF, press_off);
        program_reg(REG_TURN_ON_DELAY, turn_on);
        program_reg(REG_SHUTDOWN_WAIT, shutdown);
        program_reg(REG_CLEAR_PRECHG, clear_prechg);
        check_all_regs();
    endtask

    task automatic queue_run(input logic level, input int count);
        repeat (count) begin
            button_q.push_back(level);
            words_queued++;
        end
    endtask

    // Mostly release-then-hold runs sized around the threshold, with some noise.
    task automatic queue_random_words(input int count);
        int n;
        int run;
        int cap;
        n   = 0;
        cap = (press_off_reg < 40) ? int'(press_off_reg) + 4 : 40;
        while (n < count) begin
            if ($urandom_range(0, 99) < 15) begin
                queue_run($urandom_range(0, 1) == 1, 1);
                n++;
            end else begin
                run = $urandom_range(1, 4);
                queue_run(1'b0, run);
                n += run;
                run = $urandom_range(1, cap);
                queue_run(1'b1, run);
                n += run;
            end
        end
    endtask

    // Every word yields one result, so the block is idle once all have come back.
    task automatic wait_drained();
        while (results_seen < words_queued) @(posedge aclk);
    endtask

    initial begin
        press_off_reg    = RST_PRESS_OFF;
        turn_on_reg      = RST_TURN_ON_DELAY;
        shutdown_reg     = RST_SHUTDOWN_WAIT;
        clear_prechg_reg = RST_CLEAR_PRECHG;
        seq_phase     = PH_BOOTED;
        seq_wait      = '0;
        seq_press     = '0;
        seq_hold      = 1'b1;
        seq_precharge = 1'b0;
        seq_bright    = BRIGHT_INITIAL;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        check_all_regs();

        // With the reset settings the block only leaves booted and starts its delay.
        queue_run(1'b0, 3);
        queue_run(1'b1, 3);
        wait_drained();

        // One-tick waits and a zero threshold: the first held tick shuts down.
        program_all(0, 1, 1, 1);
        queue_run(1'b1, 3);
        queue_run(1'b0, 1);
        queue_run(1'b1, 1);
        queue_run(1'b0, 3);
        queue_run(1'b1, 2);
        wait_drained();

        // Zero waits act as one tick, precharge survives the shutdown, and the
        // press count kept from the last shutdown carries into the next on phase.
        program_all(2, 0, 0, 0);
        queue_run(1'b0, 1);
        queue_run(1'b1, 4);
        queue_run(1'b0, 3);
        queue_run(1'b1, 2);
        wait_drained();

        for (int ph = 0; ph < 11; ph++) begin
            steady = (ph == 5);
            program_all(($urandom_range(0, 99) < 20) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 12),
                        $urandom_range(0, 12), $urandom_range(0, 12),
                        $urandom_range(0, 1));
            queue_random_words(110);
            wait_drained();
        end
        steady = 1'b0;

        // Threshold at the counter maximum: a held button never shuts down.
        steady = 1'b1;
        program_all(16'hFFFF, 0, 0, 0);
        queue_run(1'b0, 4);
        queue_run(1'b1, 60);
        queue_run(1'b0, 4);
        wait_drained();
        steady = 1'b0;

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("tb_power_switch_controller_unit passed");
        end else begin
            $display("tb_power_switch_controller_unit failed");
        end
        $finish;
    end

endmodule
